[sv/integer_point_in_polygon_defines.svh]
`ifndef INTEGER_POINT_IN_POLYGON_DEFINES_SVH
`define INTEGER_POINT_IN_POLYGON_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define IPIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define IPIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ipip_pkg.sv]
package ipip_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int COORD_BITS   = 16;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int VTX_W        = 2 * COORD_BITS;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_TEST   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]                   kind;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
	} ipip_req_t;

	typedef struct packed {
		logic inside_res;
		logic truncated;
	} ipip_res_t;

	// controller -> datapath
	typedef struct packed {
		logic clr;
		logic app;
		logic tst;
		logic step;
	} ipip_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic walk_last;
	} ipip_sts_t;

endpackage

[sv/ipip_ram.sv]
module ipip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/ipip_ctrl.sv]
module ipip_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ipip_pkg::ipip_req_t   req,
	input  ipip_pkg::ipip_sts_t   sts,
	output ipip_pkg::ipip_cmd_t   cmd,
	output logic                  busy,
	output logic                  done
);
	import ipip_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_WALK   = 5'b00010,
		ST_FLUSH1 = 5'b00100,
		ST_FLUSH2 = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_RESULT);

	assign cmd.clr  = accept && (req.kind == KIND_CLEAR);
	assign cmd.app  = accept && (req.kind == KIND_APPEND);
	assign cmd.tst  = accept && (req.kind == KIND_TEST);
	assign cmd.step = (state_q == ST_WALK);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.tst) begin
					// empty polygon: parity stays clear, report at once
					state_d = sts.empty ? ST_RESULT : ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.walk_last) begin
					state_d = ST_FLUSH1;
				end
			end
			ST_FLUSH1: state_d = ST_FLUSH2;
			ST_FLUSH2: state_d = ST_RESULT;
			ST_RESULT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/ipip_dpath.sv]
module ipip_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  ipip_pkg::ipip_req_t req,
	input  ipip_pkg::ipip_cmd_t cmd,
	output ipip_pkg::ipip_sts_t sts,
	output ipip_pkg::ipip_res_t res
);
	import ipip_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             full;

	logic [CNT_W-1:0] walk_cnt_q;
	logic [CNT_W-1:0] rd_sel;
	logic [VTX_W-1:0] rd_data;

	logic signed [COORD_BITS-1:0] tx_q, ty_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] cur_x, cur_y;

	logic valid_s1, first_s1;

	logic signed [DIFF_W-1:0] dy, dtx, dxp, dty;
	logic signed [PROD_W-1:0] lhs, rhs;
	logic                     straddle;

	logic signed [PROD_W-1:0] lhs_s2, rhs_s2;
	logic                     dypos_s2, cross_s2;
	logic                     flip;
	logic                     parity_q;

	assign full = (count_q == CNT_W'(MAX_VERTICES));

	// read order: last vertex first (as the wrap-around previous), then 0 .. n-1
	assign rd_sel = (walk_cnt_q == '0) ? (count_q - CNT_W'(1)) : (walk_cnt_q - CNT_W'(1));

	ipip_ram #(
		.WIDTH (VTX_W),
		.DEPTH (MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (cmd.app && !full),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({req.coord_x, req.coord_y}),
		.re    (cmd.step),
		.raddr (rd_sel[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	assign sts.empty     = (count_q == '0);
	assign sts.walk_last = (walk_cnt_q == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			walk_cnt_q <= '0;
			valid_s1   <= 1'b0;
			first_s1   <= 1'b0;
			cross_s2   <= 1'b0;
			parity_q   <= 1'b0;
		end else begin
			if (cmd.clr) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.app) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end

			if (cmd.tst) begin
				walk_cnt_q <= '0;
			end else if (cmd.step) begin
				walk_cnt_q <= walk_cnt_q + CNT_W'(1);
			end

			valid_s1 <= cmd.step;
			first_s1 <= cmd.step && (walk_cnt_q == '0);
			cross_s2 <= valid_s1 && !first_s1 && straddle;

			if (cmd.tst) begin
				parity_q <= 1'b0;
			end else if (flip) begin
				parity_q <= ~parity_q;
			end
		end
	end

	assign cur_x = rd_data[VTX_W-1:COORD_BITS];
	assign cur_y = rd_data[COORD_BITS-1:0];

	// edge runs from prev to cur; compare cross-multiplied to avoid the divide
	assign dy       = DIFF_W'(prev_y_q) - DIFF_W'(cur_y);
	assign dtx      = DIFF_W'(tx_q) - DIFF_W'(cur_x);
	assign dxp      = DIFF_W'(prev_x_q) - DIFF_W'(cur_x);
	assign dty      = DIFF_W'(ty_q) - DIFF_W'(cur_y);
	assign lhs      = PROD_W'(dtx) * PROD_W'(dy);
	assign rhs      = PROD_W'(dxp) * PROD_W'(dty);
	assign straddle = (cur_y > ty_q) != (prev_y_q > ty_q);

	always_ff @(posedge clk) begin
		if (cmd.tst) begin
			tx_q <= req.coord_x;
			ty_q <= req.coord_y;
		end
		if (valid_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		lhs_s2   <= lhs;
		rhs_s2   <= rhs;
		dypos_s2 <= !dy[DIFF_W-1];
	end

	// dy is never zero on a straddling edge, so the sign bit decides dy > 0
	assign flip = cross_s2 && (dypos_s2 ? (lhs_s2 <= rhs_s2) : (lhs_s2 >= rhs_s2));

	assign res.inside_res = parity_q;
	assign res.truncated  = ovf_q;

endmodule

[sv/integer_point_in_polygon.sv]
// Clear and append requests complete in the accept cycle; busy stays low.
// A test request with n stored vertices holds busy for n + 1 reads of the single
// vertex RAM read port (one edge per cycle), the pipeline flush states FLUSH1 and FLUSH2, one result.
// done pulses in the last busy cycle; an empty polygon answers in the cycle after accept.
// Results cannot be stalled. arst_n clears vertex count, overflow flag and the FSM;
// the vertex RAM is not cleared.
`include "integer_point_in_polygon_defines.svh"

module integer_point_in_polygon (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ipip_pkg::ipip_req_t req,
	output logic                busy,
	output logic                done,
	output ipip_pkg::ipip_res_t res
);
	import ipip_pkg::*;

	ipip_cmd_t cmd;
	ipip_sts_t sts;

	ipip_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ipip_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	`IPIP_ASSERT_NOW(a_done_in_busy, done, busy, "result strobe outside a test")
	`IPIP_ASSERT_NOW(a_step_in_busy, cmd.step, busy, "vertex read outside a test")
	`IPIP_ASSERT_NOW(a_app_idle, cmd.app || cmd.clr, !busy, "store update during a test")
	`IPIP_ASSERT_NEXT(a_test_busy, start && !busy && (req.kind == KIND_TEST), busy,
		"test request did not start a walk")

endmodule

[verif/integer_point_in_polygon_test.sv]
`timescale 1ns / 1ps

module integer_point_in_polygon_test;
	import ipip_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         ITEM_GOAL   = 500;

	// Keeps its own copy of the polygon and a queue of expected test answers.
	class polygon_scoreboard;
		logic signed [COORD_BITS-1:0] corner_x [MAX_VERTICES];
		logic signed [COORD_BITS-1:0] corner_y [MAX_VERTICES];
		int        corner_count   = 0;
		bit        append_dropped = 0;
		ipip_res_t answer_q [$];
		int        failures       = 0;

		// even-odd crossing count, divide-free edge test
		function bit encloses(longint tx, longint ty);
			bit     odd;
			int     prev;
			longint xc, yc, xp, yp, dy, lhs, rhs;
			odd = 1'b0;
			if (corner_count == 0) return 1'b0;
			prev = corner_count - 1;
			for (int i = 0; i < corner_count; i++) begin
				xc = corner_x[i];
				yc = corner_y[i];
				xp = corner_x[prev];
				yp = corner_y[prev];
				if ((yc > ty) != (yp > ty)) begin
					dy  = yp - yc;
					lhs = (tx - xc) * dy;
					rhs = (xp - xc) * (ty - yc);
					if (dy > 0) begin
						if (lhs <= rhs) odd = !odd;
					end else if (lhs >= rhs) begin
						odd = !odd;
					end
				end
				prev = i;
			end
			return odd;
		endfunction

		function void note_request(ipip_req_t r);
			ipip_res_t e;
			case (r.kind)
				KIND_CLEAR: begin
					corner_count   = 0;
					append_dropped = 1'b0;
				end
				KIND_APPEND: begin
					if (corner_count < MAX_VERTICES) begin
						corner_x[corner_count] = r.coord_x;
						corner_y[corner_count] = r.coord_y;
						corner_count++;
					end else begin
						append_dropped = 1'b1;
					end
				end
				KIND_TEST: begin
					e.inside_res = encloses(r.coord_x, r.coord_y);
					e.truncated  = append_dropped;
					answer_q = {answer_q, e};
				end
				default: ;
			endcase
		endfunction

		function void check_answer(ipip_res_t got);
			ipip_res_t e;
			if (answer_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result inside_res=%0b truncated=%0b",
						$realtime, got.inside_res, got.truncated);
				return;
			end
			e = answer_q.pop_front();
			if (got.inside_res !== e.inside_res || got.truncated !== e.truncated) begin
				failures++;
				if (failures <= 10)
					$display("%0t: mismatch inside_res exp %0b got %0b, truncated exp %0b got %0b",
						$realtime, e.inside_res, got.inside_res, e.truncated, got.truncated);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	ipip_req_t req;
	logic      busy;
	logic      done;
	ipip_res_t res;

	polygon_scoreboard sb;
	int                issued;
	bit                idle_on;

	integer_point_in_polygon dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.res    (res)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_answer(res);
			if (start && !busy) sb.note_request(req);
		end
	end

	// Hold the request until taken; the next one follows at once unless idle_on.
	task automatic issue(logic [1:0] k, int x, int y);
		ipip_req_t r;
		r.kind    = k;
		r.coord_x = x[COORD_BITS-1:0];
		r.coord_y = y[COORD_BITS-1:0];
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (k != KIND_UNUSED) issued++;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.answer_q.size() != 0) @(posedge clk);
	endtask

	function automatic int pick(int span);
		if (span <= 0) return int'($urandom_range(0, 65535)) - 32768;
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly a clear, a vertex list and a few tests; sometimes no clear, some noise.
	task automatic random_polygon(int n_corners, int span, int n_tests, bit force_clear);
		int px [$];
		int py [$];
		int x, y, j;
		if (force_clear || $urandom_range(0, 9) != 0)
			issue(KIND_CLEAR, pick(0), pick(0));
		for (int i = 0; i < n_corners; i++) begin
			x = pick(span);
			y = pick(span);
			px = {px, x};
			py = {py, y};
			issue(KIND_APPEND, x, y);
			if ($urandom_range(0, 14) == 0) issue(KIND_UNUSED, pick(0), pick(0));
		end
		for (int i = 0; i < n_tests; i++) begin
			x = (span > 0) ? pick(span + 2) : pick(0);
			y = (span > 0) ? pick(span + 2) : pick(0);
			// landing on a vertex row or column exercises the equality cases
			if (px.size() != 0 && $urandom_range(0, 3) == 0) begin
				j = $urandom_range(0, px.size() - 1);
				if ($urandom_range(0, 1)) x = px[j];
				if ($urandom_range(0, 1)) y = py[j];
			end
			issue(KIND_TEST, x, y);
		end
	endtask

	initial begin
		int  n, span;
		bit  big_done;
		sb       = new();
		issued   = 0;
		idle_on  = 1'b0;
		big_done = 1'b0;
		start  <= 1'b0;
		req    <= '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty, one and two vertices
		issue(KIND_TEST, 0, 0);
		issue(KIND_APPEND, 5, 5);
		issue(KIND_TEST, 5, 4);
		issue(KIND_APPEND, -5, -5);
		issue(KIND_TEST, 0, 0);
		issue(KIND_TEST, 0, 4);
		// square at the coordinate extremes
		issue(KIND_CLEAR, 0, 0);
		issue(KIND_APPEND, -32768, -32768);
		issue(KIND_APPEND, 32767, -32768);
		issue(KIND_APPEND, 32767, 32767);
		issue(KIND_APPEND, -32768, 32767);
		issue(KIND_TEST, 0, 0);
		issue(KIND_TEST, -32768, -32768);
		issue(KIND_TEST, 32767, 32767);
		issue(KIND_TEST, -32768, 0);
		issue(KIND_TEST, 32767, 0);
		issue(KIND_UNUSED, -1, -1);
		issue(KIND_TEST, -1, -1);
		// triangle with sharp slopes
		issue(KIND_CLEAR, -1, -1);
		issue(KIND_APPEND, -32768, 0);
		issue(KIND_APPEND, 32767, 1);
		issue(KIND_APPEND, 0, 32767);
		issue(KIND_TEST, 0, 1);
		issue(KIND_TEST, 32767, 1);
		issue(KIND_CLEAR, 0, 0);
		issue(KIND_TEST, 0, 0);
		settle();

		while (issued < ITEM_GOAL) begin
			idle_on = (issued > ITEM_GOAL - 100) ? 1'b0 : ($urandom_range(0, 2) != 0);
			if (!big_done && issued > 150) begin
				// fill the store past its end so appends get dropped
				random_polygon(MAX_VERTICES + $urandom_range(1, 4), 0, 3, 1'b1);
				big_done = 1'b1;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
				case ($urandom_range(0, 4))
					0:       span = 0;
					1:       span = 8;
					2:       span = 30;
					3:       span = 100;
					default: span = 2000;
				endcase
				random_polygon(n, span, $urandom_range(1, 6), 1'b0);
			end
			if ($urandom_range(0, 5) == 0) settle();
		end

		settle();
		repeat (12) @(posedge clk);
		if (sb.failures == 0 && sb.answer_q.size() == 0)
			$display("integer_point_in_polygon_test OK");
		else
			$display("integer_point_in_polygon_test NOT OK");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("integer_point_in_polygon_test NOT OK");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/ipip_pkg.sv
sv/ipip_ram.sv
sv/ipip_ctrl.sv
sv/ipip_dpath.sv
sv/integer_point_in_polygon.sv
verif/integer_point_in_polygon_test.sv
